### hw/rtl/vertex_project_viewport_macros.svh
// ----------------------------------------------------------------------------
// vertex_project_viewport assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef VERTEX_PROJECT_VIEWPORT_MACROS_SVH
`define VERTEX_PROJECT_VIEWPORT_MACROS_SVH

// check while out of reset
`define VPV_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("vertex_project_viewport assertion failed");

// check during reset as well
`define VPV_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("vertex_project_viewport assertion failed");

`endif

### hw/rtl/vpv_pkg.sv
// ----------------------------------------------------------------------------
// vpv_pkg
// Types, widths and constants of the vertex projection and viewport block.
// ----------------------------------------------------------------------------
package vpv_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   localparam int NREG   = 8;
   localparam int AW     = 6;
   localparam int RIW    = 3;
   localparam int CW     = 50;
   localparam int NUMW   = CW + 1;
   localparam int DW     = CW;
   localparam int QB     = 33;
   localparam int NW     = 80;
   localparam int LANES  = 4;
   localparam int QDEPTH = 4;
   localparam int QPW    = 2;

   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;
   localparam int LANE_R = 3;

   localparam logic signed [CW-1:0] W_REJECT_MAX = CW'(6);

   localparam logic [NW-1:0] SCALE_X   = NW'(SCREEN_WIDTH) << 15;
   localparam logic [NW-1:0] SCALE_Y   = NW'(SCREEN_HEIGHT) << 15;
   localparam logic [NW-1:0] SCALE_Z   = NW'(1) << 16;
   localparam logic [NW-1:0] RECIP_NUM = NW'(1) << 32;

   typedef logic [NREG-1:0][63:0] mat_type;

   localparam mat_type MAT_RESET = {
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
      64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};

   typedef struct packed {
      logic [15:0]        red;
      logic [15:0]        green;
      logic [15:0]        blue;
      logic signed [31:0] u;
      logic signed [31:0] v;
   } attr_type;

   typedef struct packed {
      logic                       visible;
      logic [LANES-1:0]           neg;
      logic [LANES-1:0][NW-1:0]   num;
      logic [DW-1:0]              den;
      attr_type                   attr;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } q_wr_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } q_rd_type;

   typedef struct packed {
      logic                       visible;
      logic [LANES-1:0]           sat;
      logic [LANES-1:0]           neg;
      logic [LANES-1:0][DW-1:0]   rem;
      logic [LANES-1:0][QB-1:0]   nlow;
      logic [LANES-1:0][QB-1:0]   quo;
      logic [DW-1:0]              den;
      attr_type                   attr;
   } div_type;

endpackage

### hw/rtl/vpv_csr.sv
// ----------------------------------------------------------------------------
// vpv_csr
// APB register file holding the eight 64-bit matrix registers.
// ----------------------------------------------------------------------------
module vpv_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [vpv_pkg::AW-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready,
   output vpv_pkg::mat_type      mat
);
   import vpv_pkg::*;

   mat_type        mat_ff;
   mat_type        mat_in;
   logic [RIW-1:0] idx;
   logic           wr_en;

   assign idx        = csr_paddr[AW-1:AW-RIW];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = mat_ff[idx];
   assign mat        = mat_ff;

   always_comb begin
      mat_in = mat_ff;
      if (wr_en) begin
         mat_in[idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else begin
         mat_ff <= mat_in;
      end
   end

endmodule

### hw/rtl/vpv_front.sv
// ----------------------------------------------------------------------------
// vpv_front
// Front pipeline: matrix transform, clip test and numerator set-up.
// ----------------------------------------------------------------------------
module vpv_front (
   input  logic               clock,
   input  logic               reset,
   input  vpv_pkg::mat_type   mat,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_color_red,
   input  logic [15:0]        req_color_green,
   input  logic [15:0]        req_color_blue,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic               q_full,
   output vpv_pkg::q_wr_type  q_wr
);
   import vpv_pkg::*;

   function automatic logic signed [31:0] coef(mat_type m, int row, int col);
      logic [63:0] r;
      r = m[row * 2 + col / 2];
      return (col % 2 == 1) ? r[63:32] : r[31:0];
   endfunction

   logic [4:0]               valid_ff;
   logic [4:0]               valid_in;
   logic                     en;

   logic signed [31:0]       pos_ff [3];
   attr_type                 attr1_ff;
   logic signed [63:0]       prod_ff [4][3];
   logic signed [63:0]       prod_in [4][3];
   attr_type                 attr2_ff;
   logic signed [65:0]       sum [4];
   logic signed [CW-1:0]     clip_ff [4];
   logic signed [CW-1:0]     clip_in [4];
   attr_type                 attr3_ff;
   logic signed [NUMW-1:0]   num_ff [3];
   logic signed [NUMW-1:0]   num_in [3];
   logic                     vis_ff;
   logic [DW-1:0]            den_ff;
   attr_type                 attr4_ff;
   logic [NUMW-1:0]          mag [3];
   logic [NW-1:0]            scale [3];
   job_type                  job_ff;
   job_type                  job_in;

   assign en       = !valid_ff[4] || !q_full;
   assign req_full = !en;
   assign valid_in = {valid_ff[3:0], req_push};
   assign q_wr     = '{push: valid_ff[4] && !q_full, job: job_ff};

   assign scale[LANE_X] = SCALE_X;
   assign scale[LANE_Y] = SCALE_Y;
   assign scale[LANE_Z] = SCALE_Z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[r][j] = coef(mat, r, j) * pos_ff[j];
         end
         sum[r] = 66'(prod_ff[r][0]) + 66'(prod_ff[r][1]) + 66'(prod_ff[r][2]);
         clip_in[r] = CW'(sum[r] >>> 16) + CW'(coef(mat, r, 3));
      end
      num_in[LANE_X] = NUMW'(clip_ff[0]) + NUMW'(clip_ff[3]);
      num_in[LANE_Y] = NUMW'(clip_ff[3]) - NUMW'(clip_ff[1]);
      num_in[LANE_Z] = NUMW'(clip_ff[2]);
      job_in.visible = vis_ff;
      job_in.den     = den_ff;
      job_in.attr    = attr4_ff;
      for (int i = 0; i < 3; i++) begin
         job_in.neg[i] = num_ff[i][NUMW-1];
         mag[i] = job_in.neg[i] ? NUMW'(-num_ff[i]) : NUMW'(num_ff[i]);
         job_in.num[i] = NW'(mag[i]) * scale[i];
      end
      job_in.neg[LANE_R] = 1'b0;
      job_in.num[LANE_R] = RECIP_NUM;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         attr1_ff  <= '{red: req_color_red, green: req_color_green,
                        blue: req_color_blue, u: req_tex_u, v: req_tex_v};
         prod_ff   <= prod_in;
         attr2_ff  <= attr1_ff;
         clip_ff   <= clip_in;
         attr3_ff  <= attr2_ff;
         num_ff    <= num_in;
         vis_ff    <= clip_ff[3] > W_REJECT_MAX;
         den_ff    <= DW'(clip_ff[3]);
         attr4_ff  <= attr3_ff;
         job_ff    <= job_in;
      end
   end

endmodule

### hw/rtl/vpv_queue.sv
// ----------------------------------------------------------------------------
// vpv_queue
// Short job queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module vpv_queue (
   input  logic              clock,
   input  logic              reset,
   input  vpv_pkg::q_wr_type wr,
   output logic              full,
   input  logic              pop,
   output vpv_pkg::q_rd_type rd
);
   import vpv_pkg::*;

   job_type        entry_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff;
   logic [QPW-1:0] wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff;
   logic [QPW-1:0] rd_ptr_in;
   logic [QPW:0]   count_ff;
   logic [QPW:0]   count_in;
   logic           do_pop;

   assign full   = count_ff == (QPW+1)'(QDEPTH);
   assign do_pop = pop && count_ff != '0;
   assign rd     = '{valid: count_ff != '0, job: entry_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPW'(wr.push);
      rd_ptr_in = rd_ptr_ff + QPW'(do_pop);
      count_in  = count_ff + (QPW+1)'(wr.push) - (QPW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         entry_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

### hw/rtl/vpv_back.sv
// ----------------------------------------------------------------------------
// vpv_back
// Back pipeline: four-lane restoring divider, rounding, saturation, result.
// ----------------------------------------------------------------------------
module vpv_back (
   input  logic               clock,
   input  logic               reset,
   input  vpv_pkg::q_rd_type  rd,
   output logic               pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic               rsp_visible,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_depth,
   output logic signed [31:0] rsp_recip_w,
   output logic [15:0]        rsp_out_red,
   output logic [15:0]        rsp_out_green,
   output logic [15:0]        rsp_out_blue,
   output logic signed [31:0] rsp_out_u,
   output logic signed [31:0] rsp_out_v
);
   import vpv_pkg::*;

   function automatic div_type div_step(div_type s);
      div_type       n;
      logic [DW:0]   trial;
      n = s;
      for (int l = 0; l < LANES; l++) begin
         trial = {s.rem[l], s.nlow[l][QB-1]};
         n.nlow[l] = s.nlow[l] << 1;
         if (trial >= {1'b0, s.den}) begin
            n.rem[l] = DW'(trial - {1'b0, s.den});
            n.quo[l] = {s.quo[l][QB-2:0], 1'b1};
         end else begin
            n.rem[l] = trial[DW-1:0];
            n.quo[l] = {s.quo[l][QB-2:0], 1'b0};
         end
      end
      return n;
   endfunction

   logic [QB:0]              valid_ff;
   div_type                  st_ff [QB+1];
   div_type                  st_in [QB+1];
   logic [NW-1:0]            hi [LANES];
   logic                     en;

   logic                     out_valid_ff;
   logic                     vis_ff;
   logic [LANES-1:0][31:0]   res_ff;
   logic [LANES-1:0][31:0]   res_in;
   attr_type                 attr_ff;
   attr_type                 attr_in;
   logic                     rnd [LANES];
   logic [QB:0]              qr [LANES];
   logic [QB:0]              limit [LANES];
   div_type                  fin;

   assign en  = !out_valid_ff || rsp_pop;
   assign pop = en && rd.valid;
   assign fin = st_ff[QB];

   always_comb begin
      st_in[0].visible = rd.job.visible;
      st_in[0].neg     = rd.job.neg;
      st_in[0].den     = rd.job.den;
      st_in[0].attr    = rd.job.attr;
      for (int l = 0; l < LANES; l++) begin
         hi[l] = rd.job.num[l] >> QB;
         st_in[0].sat[l]  = hi[l] >= NW'(rd.job.den);
         st_in[0].rem[l]  = DW'(hi[l]);
         st_in[0].nlow[l] = rd.job.num[l][QB-1:0];
         st_in[0].quo[l]  = '0;
      end
      for (int k = 1; k <= QB; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rnd[l]   = {fin.rem[l], 1'b0} >= {1'b0, fin.den};
         qr[l]    = (QB+1)'(fin.quo[l]) + (QB+1)'(rnd[l]);
         limit[l] = fin.neg[l] ? (QB+1)'(34'h0_8000_0000) : (QB+1)'(34'h0_7FFF_FFFF);
         if (fin.sat[l] || qr[l] > limit[l]) begin
            qr[l] = limit[l];
         end
         res_in[l] = fin.neg[l] ? -qr[l][31:0] : qr[l][31:0];
         if (!fin.visible) begin
            res_in[l] = '0;
         end
      end
      attr_in = fin.visible ? fin.attr : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[QB-1:0], rd.valid};
         out_valid_ff <= valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff   <= st_in;
         vis_ff  <= fin.visible;
         res_ff  <= res_in;
         attr_ff <= attr_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_visible   = vis_ff;
   assign rsp_screen_x  = res_ff[LANE_X];
   assign rsp_screen_y  = res_ff[LANE_Y];
   assign rsp_depth     = res_ff[LANE_Z];
   assign rsp_recip_w   = res_ff[LANE_R];
   assign rsp_out_red   = attr_ff.red;
   assign rsp_out_green = attr_ff.green;
   assign rsp_out_blue  = attr_ff.blue;
   assign rsp_out_u     = attr_ff.u;
   assign rsp_out_v     = attr_ff.v;

endmodule

### hw/rtl/vertex_project_viewport.sv
// ----------------------------------------------------------------------------
// vertex_project_viewport
// Perspective projection and viewport mapping of a vertex stream.
//
//   channel  | ports   | handshake
//   ---------+---------+-------------------------------
//   input    | req_*   | push / full
//   result   | rsp_*   | empty / pop
//   config   | csr_*   | APB, 64-bit data, reg i at 8*i
//
// One vertex per cycle sustained while results are popped; a vertex passes the
// front pipeline, the queue, the divider and one result register.
// The divider is a 33-stage restoring pipeline, one quotient bit a stage.
// Reset is synchronous and clears all pipeline valids and the queue.
// A blocked result stalls the back pipeline; the four-entry queue then fills
// and stalls the front, which raises full.
// ----------------------------------------------------------------------------
module vertex_project_viewport (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [31:0]     req_pos_z,
   input  logic [15:0]            req_color_red,
   input  logic [15:0]            req_color_green,
   input  logic [15:0]            req_color_blue,
   input  logic signed [31:0]     req_tex_u,
   input  logic signed [31:0]     req_tex_v,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_visible,
   output logic signed [31:0]     rsp_screen_x,
   output logic signed [31:0]     rsp_screen_y,
   output logic signed [31:0]     rsp_depth,
   output logic signed [31:0]     rsp_recip_w,
   output logic [15:0]            rsp_out_red,
   output logic [15:0]            rsp_out_green,
   output logic [15:0]            rsp_out_blue,
   output logic signed [31:0]     rsp_out_u,
   output logic signed [31:0]     rsp_out_v,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [vpv_pkg::AW-1:0] csr_paddr,
   input  logic [63:0]            csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);
   import vpv_pkg::*;

   mat_type  mat;
   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_pop;

   vpv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mat         (mat)
   );

   vpv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .mat             (mat),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_color_red   (req_color_red),
      .req_color_green (req_color_green),
      .req_color_blue  (req_color_blue),
      .req_tex_u       (req_tex_u),
      .req_tex_v       (req_tex_v),
      .q_full          (q_full),
      .q_wr            (q_wr)
   );

   vpv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .pop   (q_pop),
      .rd    (q_rd)
   );

   vpv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .rd            (q_rd),
      .pop           (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_visible   (rsp_visible),
      .rsp_screen_x  (rsp_screen_x),
      .rsp_screen_y  (rsp_screen_y),
      .rsp_depth     (rsp_depth),
      .rsp_recip_w   (rsp_recip_w),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_u     (rsp_out_u),
      .rsp_out_v     (rsp_out_v)
   );

endmodule

### hw/rtl/vpv_checker.sv
// ----------------------------------------------------------------------------
// vpv_checker
// Port-level checks of the vertex projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_project_viewport_macros.svh"

module vpv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_visible,
   input logic [31:0] rsp_screen_x,
   input logic [31:0] rsp_recip_w,
   input logic [15:0] rsp_out_red,
   input logic [31:0] rsp_out_u
);

   `VPV_ASSERT_ALWAYS(a_empty_after_reset, reset |=> rsp_empty)
   `VPV_ASSERT(a_result_holds, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_screen_x))
   `VPV_ASSERT(a_reject_zero, !rsp_empty && !rsp_visible |-> rsp_screen_x == 0 && rsp_recip_w == 0 && rsp_out_red == 0 && rsp_out_u == 0)
   `VPV_ASSERT(a_recip_nonneg, !rsp_empty && rsp_visible |-> !rsp_recip_w[31])

endmodule

bind vertex_project_viewport vpv_checker u_checker (.*);

### bench/tb_vertex_project_viewport.sv
// ----------------------------------------------------------------------------
// tb_vertex_project_viewport
// Self-checking bench for the vertex projection and viewport block. Directed
// vectors and random vertices are sent through the input queue under several
// matrix settings. Results are checked by a behavioral model or set values.
// Both sides idle at random. One long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vertex_project_viewport;
   import vpv_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        red;
      logic [15:0]        green;
      logic [15:0]        blue;
      logic signed [31:0] u;
      logic signed [31:0] v;
   } vertex_type;

   typedef struct packed {
      logic               visible;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] depth;
      logic signed [31:0] rw;
      logic [15:0]        red;
      logic [15:0]        green;
      logic [15:0]        blue;
      logic signed [31:0] u;
      logic signed [31:0] v;
   } pixel_type;

   typedef struct {
      vertex_type vtx;
      logic       typed;
      pixel_type  pix;
   } vector_type;

   localparam int LIMIT_CYCLES = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   vertex_type drv = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_visible;
   logic signed [31:0] rsp_screen_x, rsp_screen_y, rsp_depth, rsp_recip_w;
   logic [15:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic signed [31:0] rsp_out_u, rsp_out_v;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [AW-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   logic [63:0] matrix [NREG];
   pixel_type pending_pixels [$];
   int errors = 0;
   int checked = 0;
   int visible_count = 0;
   int cycles = 0;
   bit hold_pop = 1'b0;
   bit sending_done = 1'b0;

   always #4 clock = ~clock;

   vertex_project_viewport uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_pos_x(drv.x), .req_pos_y(drv.y), .req_pos_z(drv.z),
      .req_color_red(drv.red), .req_color_green(drv.green), .req_color_blue(drv.blue),
      .req_tex_u(drv.u), .req_tex_v(drv.v),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_visible(rsp_visible), .rsp_screen_x(rsp_screen_x),
      .rsp_screen_y(rsp_screen_y), .rsp_depth(rsp_depth), .rsp_recip_w(rsp_recip_w),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_out_u(rsp_out_u), .rsp_out_v(rsp_out_v),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic logic signed [63:0] coefficient(int row, int col);
      logic [63:0] r;
      r = matrix[row * 2 + col / 2];
      return (col % 2) ? $signed(r[63:32]) : $signed(r[31:0]);
   endfunction

   // floor of the exact Q32.32 sum, kept wide
   function automatic logic signed [63:0] clip_coord(int row, vertex_type vtx);
      logic signed [127:0] acc;
      acc = 128'(coefficient(row, 3)) <<< 16;
      acc += 128'(coefficient(row, 0)) * 128'(64'(vtx.x));
      acc += 128'(coefficient(row, 1)) * 128'(64'(vtx.y));
      acc += 128'(coefficient(row, 2)) * 128'(64'(vtx.z));
      return 64'(acc >>> 16);
   endfunction

   // round(n * scale / d), ties away from zero, saturated to 32 bits
   function automatic logic signed [31:0] scaled_ratio(logic signed [63:0] n,
                                                        logic [63:0] scale,
                                                        logic signed [63:0] d);
      logic [127:0] mag, q, r;
      logic neg;
      neg = n < 0;
      mag = (neg ? 128'(-n) : 128'(n)) * 128'(scale);
      q = mag / 128'(d);
      r = mag % 128'(d);
      if (r >= 128'(d) - r) q++;
      if (!neg && q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
      if (neg && q > 128'h8000_0000) return 32'h8000_0000;
      return neg ? -32'(q) : 32'(q);
   endfunction

   function automatic pixel_type project_vertex(vertex_type vtx);
      pixel_type p;
      logic signed [63:0] cx, cy, cz, cw;
      p = '0;
      cx = clip_coord(0, vtx);
      cy = clip_coord(1, vtx);
      cz = clip_coord(2, vtx);
      cw = clip_coord(3, vtx);
      if (cw <= 6) return p;
      p.visible = 1'b1;
      p.sx = scaled_ratio(cx + cw, 64'(SCREEN_WIDTH) << 15, cw);
      p.sy = scaled_ratio(cw - cy, 64'(SCREEN_HEIGHT) << 15, cw);
      p.depth = scaled_ratio(cz, 64'd1 << 16, cw);
      p.rw = scaled_ratio(64'sd1, 64'd1 << 32, cw);
      p.red = vtx.red;
      p.green = vtx.green;
      p.blue = vtx.blue;
      p.u = vtx.u;
      p.v = vtx.v;
      return p;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
         2: return {$urandom_range(0, 1) ? 12'hFFF : 12'h000, 20'($urandom)};
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type vtx;
      vtx.x = rand_coord();
      vtx.y = rand_coord();
      vtx.z = rand_coord();
      vtx.red = 16'($urandom);
      vtx.green = 16'($urandom);
      vtx.blue = 16'($urandom);
      vtx.u = $urandom;
      vtx.v = $urandom;
      return vtx;
   endfunction

   task automatic write_register(int index, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= AW'(index * 8);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      matrix[index] = value;
   endtask

   task automatic load_matrix(logic [63:0] m [NREG]);
      req_push <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (50) @(posedge clock);
      for (int i = 0; i < NREG; i++) write_register(i, m[i]);
   endtask

   task automatic send_vertex(vertex_type vtx, logic typed, pixel_type pix);
      pixel_type p;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      drv <= vtx;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      p = project_vertex(vtx);
      pending_pixels.push_back(typed ? pix : p);
      @(negedge clock);
   endtask

   function automatic logic [63:0] pack_pair(logic signed [31:0] a, logic signed [31:0] b);
      return {b, a};
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_vertex(rand_vertex(), 1'b0, '0);
   endtask

   task automatic random_matrix(int scale_shift);
      logic [63:0] m [NREG];
      for (int i = 0; i < NREG; i++)
         m[i] = {32'($signed($urandom) >>> scale_shift), 32'($signed($urandom) >>> scale_shift)};
      // keep w mostly positive so most vertices are not rejected
      m[7] = {32'($urandom_range(1, 40)) << 16, 32'($signed($urandom) >>> 20)};
      load_matrix(m);
   endtask

   initial begin
      vector_type vectors [$];
      vector_type vec;
      logic [63:0] m [NREG];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NREG; i++) matrix[i] = MAT_RESET[i];

      // identity after reset: origin maps to screen center, depth 0, recip 1
      vec.vtx = '0;
      vec.vtx.red = 16'hFFFF;
      vec.vtx.u = 32'h8000_0000;
      vec.vtx.v = 32'h7FFF_FFFF;
      vec.typed = 1'b1;
      vec.pix = '0;
      vec.pix.visible = 1'b1;
      vec.pix.sx = 32'd320 << 16;
      vec.pix.sy = 32'd240 << 16;
      vec.pix.rw = 32'h0001_0000;
      vec.pix.red = 16'hFFFF;
      vec.pix.u = 32'h8000_0000;
      vec.pix.v = 32'h7FFF_FFFF;
      vectors.push_back(vec);
      vec.vtx = '0;
      vec.vtx.green = 16'hFFFF;
      vec.vtx.blue = 16'hA5A5;
      vec.vtx.x = 32'h7FFF_FFFF;
      vec.vtx.y = 32'h8000_0000;
      vec.vtx.z = 32'h7FFF_FFFF;
      vec.typed = 1'b0;
      vectors.push_back(vec);
      vec.vtx.x = 32'h8000_0000;
      vec.vtx.y = 32'h7FFF_FFFF;
      vec.vtx.z = 32'h8000_0000;
      vectors.push_back(vec);
      for (int i = 0; i < 6; i++) begin
         vec.vtx = rand_vertex();
         vectors.push_back(vec);
      end
      foreach (vectors[i]) send_vertex(vectors[i].vtx, vectors[i].typed, vectors[i].pix);

      // w taken from z: rejection at and around the threshold
      m = '{64'h0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
            64'h0, 64'h0001_0000, 64'h0, 64'h0000_0000_0001_0000};
      load_matrix(m);
      for (int w = -2; w <= 9; w++) begin
         vec.vtx = rand_vertex();
         vec.vtx.z = w;
         vec.typed = (w <= 6);
         vec.pix = '0;
         send_vertex(vec.vtx, vec.typed, vec.pix);
      end
      vec.vtx = rand_vertex();
      vec.vtx.z = 32'h8000_0000;
      send_vertex(vec.vtx, 1'b1, '0);
      vec.vtx.z = 7;
      vec.vtx.x = 32'h7FFF_FFFF;
      send_vertex(vec.vtx, 1'b0, '0);
      send_random(150);

      // extreme coefficients
      for (int i = 0; i < NREG; i++) m[i] = pack_pair(32'h7FFF_FFFF, 32'h8000_0000);
      load_matrix(m);
      send_random(60);
      for (int i = 0; i < NREG; i++) m[i] = 64'hFFFF_FFFF_FFFF_FFFF;
      load_matrix(m);
      send_random(60);
      for (int i = 0; i < NREG; i++) m[i] = 64'h8000_0000_7FFF_FFFF;
      load_matrix(m);
      send_random(60);

      for (int k = 0; k < 6; k++) begin
         random_matrix(k * 3);
         send_random(170);
      end
      req_push <= 1'b0;
      sending_done = 1'b1;
   end

   // long receiver stall while the sender keeps going
   initial begin
      wait (pending_pixels.size() > 0 && !reset);
      repeat (400) @(posedge clock);
      hold_pop = 1'b1;
      repeat (300) @(posedge clock);
      hold_pop = 1'b0;
   end

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         if (gap > 0 || hold_pop) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
            while (hold_pop) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            $error("result transaction with no vertex outstanding");
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            checked++;
            if (want.visible) visible_count++;
            if (rsp_visible !== want.visible) begin
               $error("visible: expected %0d actual %0d", want.visible, rsp_visible);
               errors++;
            end
            if (rsp_screen_x !== want.sx) begin
               $error("screen_x: expected %0d actual %0d", want.sx, rsp_screen_x);
               errors++;
            end
            if (rsp_screen_y !== want.sy) begin
               $error("screen_y: expected %0d actual %0d", want.sy, rsp_screen_y);
               errors++;
            end
            if (rsp_depth !== want.depth) begin
               $error("depth: expected %0d actual %0d", want.depth, rsp_depth);
               errors++;
            end
            if (rsp_recip_w !== want.rw) begin
               $error("recip_w: expected %0d actual %0d", want.rw, rsp_recip_w);
               errors++;
            end
            if (rsp_out_red !== want.red) begin
               $error("out_red: expected %0h actual %0h", want.red, rsp_out_red);
               errors++;
            end
            if (rsp_out_green !== want.green) begin
               $error("out_green: expected %0h actual %0h", want.green, rsp_out_green);
               errors++;
            end
            if (rsp_out_blue !== want.blue) begin
               $error("out_blue: expected %0h actual %0h", want.blue, rsp_out_blue);
               errors++;
            end
            if (rsp_out_u !== want.u) begin
               $error("out_u: expected %0h actual %0h", want.u, rsp_out_u);
               errors++;
            end
            if (rsp_out_v !== want.v) begin
               $error("out_v: expected %0h actual %0h", want.v, rsp_out_v);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (sending_done && pending_pixels.size() == 0);
      repeat (60) @(posedge clock);
      $display("checked %0d vertices, %0d visible, over 11 matrix settings",
               checked, visible_count);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("tb_vertex_project_viewport OK");
      else
         $display("tb_vertex_project_viewport NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("tb_vertex_project_viewport NOT OK");
         $finish;
      end
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vpv_pkg.sv
hw/rtl/vpv_csr.sv
hw/rtl/vpv_front.sv
hw/rtl/vpv_queue.sv
hw/rtl/vpv_back.sv
hw/rtl/vertex_project_viewport.sv
hw/rtl/vpv_checker.sv
bench/tb_vertex_project_viewport.sv
